### rtl/core/touch_gesture_to_mouse_macros.svh
// assertion macros used by the gesture block checker
`ifndef TOUCH_GESTURE_TO_MOUSE_MACROS_SVH
`define TOUCH_GESTURE_TO_MOUSE_MACROS_SVH

// same-cycle implication, ignored while in reset
`define TGM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while in reset
`define TGM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define TGM_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/tgm_pkg.sv
// types and constants of the touch gesture to mouse block
package tgm_pkg;

    localparam int COORD_BITS = 12;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;
    localparam int DIV_STEPS  = 13;

    localparam logic [31:0] MOVE_GAP_US = 32'd4000;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef enum logic [1:0] {
        EV_MOVE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2,
        EV_SCROLL  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CFG_INVERT      = 3'd0,
        CFG_TAP_MOVE    = 3'd1,
        CFG_TAP_MAX     = 3'd2,
        CFG_DTAP_GAP    = 3'd3,
        CFG_DRAG_HOLD   = 3'd4,
        CFG_NOTCH       = 3'd5,
        CFG_LHOLD_GAP   = 3'd6,
        CFG_LHOLD_RAD   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  touch_count;
        logic [11:0] first_x;
        logic [11:0] first_y;
        logic [11:0] second_x;
        logic [11:0] second_y;
        logic [31:0] time_ms;
        logic [31:0] time_us;
    } t_sample;

    typedef struct packed {
        t_kind              kind;
        logic signed [12:0] move_x;
        logic signed [12:0] move_y;
        logic signed [13:0] scroll_v;
        logic signed [13:0] scroll_h;
        logic               last;
    } t_evt;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### rtl/core/touch_gesture_to_mouse.sv
// touch panel gesture recognizer: touch samples in, mouse event words out
//
// input stream s_axis: one word per touch sample (finger count, two points,
// ms and us timestamps); s_axis_tready is high only while the front end is
// waiting for a sample.
// output stream m_axis: 0 to 3 event words per sample; tuser is the event kind,
// tlast marks the final event of a sample.
// config port: i_cfg_we writes i_cfg_data into register i_cfg_idx at the clock
// edge; write only while no sample is in flight.
// throughput: after a sample is taken in S_IDLE and evaluated in S_EVAL, the
// front end pushes one event per cycle in S_EMIT while the queue is not full;
// a scroll sample first runs the 13-step shift-subtract notch divider in S_DIV.
// event path: each event word is written into the queue and then loaded into
// the output register before it appears on m_axis.
// a 4-entry event queue sits between front and back, so a stalled receiver
// only stops the front end once the queue is full; a stalled output word holds.
// reset (synchronous, active low) clears all gesture state, empties the queue
// and loads the default configuration.
module touch_gesture_to_mouse (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // touch_count[1:0], first_x[13:2], first_y[25:14], second_x[37:26],
    // second_y[49:38], time_ms[81:50], time_us[113:82], zero fill
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // move_x[12:0], move_y[25:13], scroll_v[39:26], scroll_h[53:40], zero fill
    output logic [55:0]  m_axis_tdata,
    // event_kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    import tgm_pkg::*;

    t_sample sample;
    t_evt    f_evt, q_evt, o_evt;
    t_q_stat qstat;
    logic    push, pop;

    assign sample.touch_count = s_axis_tdata[1:0];
    assign sample.first_x     = s_axis_tdata[13:2];
    assign sample.first_y     = s_axis_tdata[25:14];
    assign sample.second_x    = s_axis_tdata[37:26];
    assign sample.second_y    = s_axis_tdata[49:38];
    assign sample.time_ms     = s_axis_tdata[81:50];
    assign sample.time_us     = s_axis_tdata[113:82];

    tgm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_sample   (sample),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_evt      (f_evt),
        .i_qstat    (qstat)
    );

    tgm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (f_evt),
        .i_pop   (pop),
        .o_evt   (q_evt),
        .o_stat  (qstat)
    );

    tgm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (q_evt),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_evt   (o_evt)
    );

    assign m_axis_tdata = {2'b00, o_evt.scroll_h, o_evt.scroll_v,
                           o_evt.move_y, o_evt.move_x};
    assign m_axis_tuser = o_evt.kind;
    assign m_axis_tlast = o_evt.last;

endmodule

### rtl/core/tgm_front.sv
// front end: takes samples, runs the gesture state and builds event words
module tgm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tgm_pkg::t_sample i_sample,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [15:0]     i_cfg_data,
    output logic            o_push,
    output tgm_pkg::t_evt   o_evt,
    input  tgm_pkg::t_q_stat i_qstat
);
    import tgm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // configuration
    logic [3:0]  r_inv;
    logic [7:0]  r_tap_move;
    logic [15:0] r_tap_max, r_dtap_gap, r_drag_hold, r_lhold_gap;
    logic [7:0]  r_notch, r_lhold_rad;

    t_state r_state, n_state;
    t_sample r_in;

    logic r_fd, n_fd, r_drag, n_drag, r_ca, n_ca, r_stf, n_stf;
    t_coord r_lsx, n_lsx, r_lsy, n_lsy, r_px, n_px, r_py, n_py;
    logic [31:0] r_ptime, n_ptime, r_sptime, n_sptime, r_lift, n_lift;
    logic r_primed, n_primed;
    logic [31:0] r_deadline, n_deadline;
    t_coord r_prx, n_prx, r_pry, n_pry;
    logic r_sact, n_sact;
    t_coord r_midx, n_midx, r_midy, n_midy;
    logic signed [13:0] r_acc_v, n_acc_v, r_acc_h, n_acc_h;
    logic [31:0] r_lmt, n_lmt;

    // divider
    logic [12:0] r_num_v, n_num_v, r_num_h, n_num_h;
    logic [12:0] r_q_v, n_q_v, r_q_h, n_q_h;
    logic [7:0]  r_rem_v, n_rem_v, r_rem_h, n_rem_h;
    logic        r_neg_v, n_neg_v, r_neg_h, n_neg_h;
    logic [3:0]  r_step, n_step;

    t_evt       r_ev [3];
    t_evt       n_ev [3];
    logic [1:0] r_ev_n, n_ev_n, r_ev_i, n_ev_i;

    t_coord x1, y1, x2, y2;
    logic [7:0] per;

    function automatic t_coord absd(input t_coord a, input t_coord b);
        return (a >= b) ? t_coord'(a - b) : t_coord'(b - a);
    endfunction

    function automatic t_evt ev_btn(input t_kind k);
        t_evt e;
        e      = '0;
        e.kind = k;
        return e;
    endfunction

    function automatic t_evt ev_move(input logic signed [12:0] dx,
                                     input logic signed [12:0] dy,
                                     input logic [3:0] inv);
        t_evt e;
        e        = '0;
        e.kind   = EV_MOVE;
        e.move_x = inv[0] ? -dx : dx;
        e.move_y = inv[1] ? -dy : dy;
        return e;
    endfunction

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [8:0] dstep(input logic [7:0] rem, input logic b,
                                         input logic [7:0] d);
        logic [8:0] t;
        logic [8:0] s;
        t = {rem, b};
        s = t - {1'b0, d};
        return (t >= {1'b0, d}) ? {1'b1, s[7:0]} : {1'b0, t[7:0]};
    endfunction

    assign x1  = r_in.first_x[COORD_BITS-1:0];
    assign y1  = r_in.first_y[COORD_BITS-1:0];
    assign x2  = r_in.second_x[COORD_BITS-1:0];
    assign y2  = r_in.second_y[COORD_BITS-1:0];
    assign per = (r_notch == 8'd0) ? 8'd1 : r_notch;

    assign o_ready = (r_state == S_IDLE);
    assign o_push  = (r_state == S_EMIT) && !i_qstat.full;
    always_comb begin
        o_evt      = r_ev[r_ev_i];
        o_evt.last = (r_ev_i == 2'(r_ev_n - 2'd1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv       <= 4'd0;
            r_tap_move  <= 8'd10;
            r_tap_max   <= 16'd180;
            r_dtap_gap  <= 16'd250;
            r_drag_hold <= 16'd200;
            r_notch     <= 8'd24;
            r_lhold_gap <= 16'd400;
            r_lhold_rad <= 8'd14;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_INVERT:    r_inv       <= i_cfg_data[3:0];
                CFG_TAP_MOVE:  r_tap_move  <= i_cfg_data[7:0];
                CFG_TAP_MAX:   r_tap_max   <= i_cfg_data;
                CFG_DTAP_GAP:  r_dtap_gap  <= i_cfg_data;
                CFG_DRAG_HOLD: r_drag_hold <= i_cfg_data;
                CFG_NOTCH:     r_notch     <= i_cfg_data[7:0];
                CFG_LHOLD_GAP: r_lhold_gap <= i_cfg_data;
                CFG_LHOLD_RAD: r_lhold_rad <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic signed [12:0] dx, dy;
        logic [12:0] sx, sy;
        t_coord ax, ay;
        logic [1:0] k;
        logic [8:0] sv, sh;
        logic signed [13:0] qv, qh;
        logic signed [12:0] dmx, dmy;
        logic [12:0] mag_v, mag_h;
        n_state = r_state;
        n_fd = r_fd; n_drag = r_drag; n_ca = r_ca; n_stf = r_stf;
        n_lsx = r_lsx; n_lsy = r_lsy; n_px = r_px; n_py = r_py;
        n_ptime = r_ptime; n_sptime = r_sptime; n_lift = r_lift;
        n_primed = r_primed; n_deadline = r_deadline; n_prx = r_prx; n_pry = r_pry;
        n_sact = r_sact; n_midx = r_midx; n_midy = r_midy;
        n_acc_v = r_acc_v; n_acc_h = r_acc_h; n_lmt = r_lmt;
        n_num_v = r_num_v; n_num_h = r_num_h; n_q_v = r_q_v; n_q_h = r_q_h;
        n_rem_v = r_rem_v; n_rem_h = r_rem_h; n_neg_v = r_neg_v; n_neg_h = r_neg_h;
        n_step = r_step;
        n_ev = r_ev; n_ev_n = r_ev_n; n_ev_i = r_ev_i;
        k = 2'd0;
        sx = {1'b0, x1} + {1'b0, x2};
        sy = {1'b0, y1} + {1'b0, y2};
        ax = sx[12:1];
        ay = sy[12:1];
        dmx = $signed({1'b0, ay}) - $signed({1'b0, r_midy});
        dmy = $signed({1'b0, ax}) - $signed({1'b0, r_midx});
        dx = $signed({1'b0, x1}) - $signed({1'b0, r_lsx});
        dy = $signed({1'b0, y1}) - $signed({1'b0, r_lsy});
        sv = dstep(r_rem_v, r_num_v[12], per);
        sh = dstep(r_rem_h, r_num_h[12], per);
        qv = r_neg_v ? -$signed({1'b0, r_q_v}) : $signed({1'b0, r_q_v});
        qh = r_neg_h ? -$signed({1'b0, r_q_h}) : $signed({1'b0, r_q_h});
        mag_v = '0;
        mag_h = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_ev_i = 2'd0;
                if (r_in.touch_count >= 2'd2) begin
                    n_midx = ax;
                    n_midy = ay;
                    if (!r_sact) begin
                        n_sact  = 1'b1;
                        n_acc_v = '0;
                        n_acc_h = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_acc_v = r_acc_v + {dmx[12], dmx};
                        n_acc_h = r_acc_h + {dmy[12], dmy};
                        mag_v   = n_acc_v[13] ? 13'(-n_acc_v) : n_acc_v[12:0];
                        mag_h   = n_acc_h[13] ? 13'(-n_acc_h) : n_acc_h[12:0];
                        n_neg_v = n_acc_v[13];
                        n_neg_h = n_acc_h[13];
                        n_num_v = mag_v;
                        n_num_h = mag_h;
                        n_rem_v = '0;
                        n_rem_h = '0;
                        n_q_v   = '0;
                        n_q_h   = '0;
                        n_step  = '0;
                        n_state = S_DIV;
                    end
                end else begin
                    if (r_sact) begin
                        n_sact  = 1'b0;
                        n_acc_v = '0;
                        n_acc_h = '0;
                    end
                    if (r_in.touch_count == 2'd1 && !r_fd) begin
                        n_fd = 1'b1;
                        n_px = x1; n_lsx = x1;
                        n_py = y1; n_lsy = y1;
                        n_ptime = r_in.time_ms;
                        n_ca = 1'b1;
                        if ((r_in.time_ms - r_lift) <= {16'd0, r_dtap_gap}) begin
                            n_stf    = 1'b1;
                            n_sptime = r_in.time_ms;
                        end else begin
                            n_stf = 1'b0;
                        end
                        if (r_primed && r_in.time_ms <= r_deadline &&
                            absd(x1, r_prx) <= t_coord'(r_lhold_rad) &&
                            absd(y1, r_pry) <= t_coord'(r_lhold_rad)) begin
                            n_stf    = 1'b1;
                            n_sptime = r_in.time_ms;
                        end
                        n_primed = 1'b0;
                    end else if (r_in.touch_count == 2'd1) begin
                        if (r_ca && (absd(x1, r_px) > t_coord'(r_tap_move) ||
                                     absd(y1, r_py) > t_coord'(r_tap_move))) begin
                            n_ca = 1'b0;
                        end
                        if (r_stf && !r_drag &&
                            (r_in.time_ms - r_sptime) >= {16'd0, r_drag_hold}) begin
                            n_drag = 1'b1;
                            n_ca   = 1'b0;
                            n_ev[k] = ev_btn(EV_PRESS);
                            k = k + 2'd1;
                        end
                        if ((r_in.time_us - r_lmt) > MOVE_GAP_US &&
                            (dx != 13'sd0 || dy != 13'sd0)) begin
                            n_ev[k] = ev_move(dx, dy, r_inv);
                            k = k + 2'd1;
                            n_lmt = r_in.time_us;
                            n_lsx = x1;
                            n_lsy = y1;
                        end
                    end else if (r_fd) begin
                        n_fd = 1'b0;
                        if (r_drag) begin
                            n_ev[k] = ev_btn(EV_RELEASE);
                            k = k + 2'd1;
                            n_drag = 1'b0;
                            n_ca   = 1'b0;
                            n_stf  = 1'b0;
                            n_lift = r_in.time_ms;
                        end else begin
                            if (dx != 13'sd0 || dy != 13'sd0) begin
                                n_ev[k] = ev_move(dx, dy, r_inv);
                                k = k + 2'd1;
                                n_lsx = x1;
                                n_lsy = y1;
                            end
                            if (r_ca && (r_in.time_ms - r_ptime) <= {16'd0, r_tap_max}) begin
                                n_ev[k] = ev_btn(EV_PRESS);
                                k = k + 2'd1;
                                n_ev[k] = ev_btn(EV_RELEASE);
                                k = k + 2'd1;
                            end
                            n_primed   = 1'b1;
                            n_deadline = r_in.time_ms + {16'd0, r_lhold_gap};
                            n_prx      = n_lsx;
                            n_pry      = n_lsy;
                            n_ca       = 1'b0;
                            n_stf      = 1'b0;
                            n_lift     = r_in.time_ms;
                        end
                    end
                    n_ev_n  = k;
                    n_state = (k == 2'd0) ? S_IDLE : S_EMIT;
                end
            end
            S_DIV: begin
                if (r_step != 4'(DIV_STEPS)) begin
                    n_rem_v = sv[7:0];
                    n_rem_h = sh[7:0];
                    n_q_v   = {r_q_v[11:0], sv[8]};
                    n_q_h   = {r_q_h[11:0], sh[8]};
                    n_num_v = {r_num_v[11:0], 1'b0};
                    n_num_h = {r_num_h[11:0], 1'b0};
                    n_step  = r_step + 4'd1;
                end else begin
                    // remainder keeps the sign of the accumulator
                    n_acc_v = r_neg_v ? -$signed({6'd0, r_rem_v}) : $signed({6'd0, r_rem_v});
                    n_acc_h = r_neg_h ? -$signed({6'd0, r_rem_h}) : $signed({6'd0, r_rem_h});
                    if (r_q_v != 13'd0 || r_q_h != 13'd0) begin
                        n_ev[0]          = ev_btn(EV_SCROLL);
                        n_ev[0].scroll_v = r_inv[2] ? -qv : qv;
                        n_ev[0].scroll_h = r_inv[3] ? -qh : qh;
                        n_ev_n  = 2'd1;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (!i_qstat.full) begin
                    if (r_ev_i == 2'(r_ev_n - 2'd1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ev_i = r_ev_i + 2'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fd <= 1'b0; r_drag <= 1'b0; r_ca <= 1'b0; r_stf <= 1'b0;
            r_lsx <= '0; r_lsy <= '0; r_px <= '0; r_py <= '0;
            r_ptime <= '0; r_sptime <= '0; r_lift <= '0;
            r_primed <= 1'b0; r_deadline <= '0; r_prx <= '0; r_pry <= '0;
            r_sact <= 1'b0; r_midx <= '0; r_midy <= '0;
            r_acc_v <= '0; r_acc_h <= '0; r_lmt <= '0;
            r_ev_n <= '0; r_ev_i <= '0; r_step <= '0;
        end else begin
            r_state <= n_state;
            r_fd <= n_fd; r_drag <= n_drag; r_ca <= n_ca; r_stf <= n_stf;
            r_lsx <= n_lsx; r_lsy <= n_lsy; r_px <= n_px; r_py <= n_py;
            r_ptime <= n_ptime; r_sptime <= n_sptime; r_lift <= n_lift;
            r_primed <= n_primed; r_deadline <= n_deadline; r_prx <= n_prx; r_pry <= n_pry;
            r_sact <= n_sact; r_midx <= n_midx; r_midy <= n_midy;
            r_acc_v <= n_acc_v; r_acc_h <= n_acc_h; r_lmt <= n_lmt;
            r_ev_n <= n_ev_n; r_ev_i <= n_ev_i; r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_in <= i_sample;
        end
        r_num_v <= n_num_v; r_num_h <= n_num_h;
        r_q_v <= n_q_v; r_q_h <= n_q_h;
        r_rem_v <= n_rem_v; r_rem_h <= n_rem_h;
        r_neg_v <= n_neg_v; r_neg_h <= n_neg_h;
        r_ev <= n_ev;
    end

endmodule

### rtl/core/tgm_queue.sv
// short event queue between the front and back ends
module tgm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tgm_pkg::t_evt    i_evt,
    input  logic             i_pop,
    output tgm_pkg::t_evt    o_evt,
    output tgm_pkg::t_q_stat o_stat
);
    import tgm_pkg::*;

    t_evt r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_evt        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_evt;
        end
    end

endmodule

### rtl/core/tgm_back.sv
// back end: output register that hands event words to the receiver
module tgm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tgm_pkg::t_evt    i_evt,
    input  tgm_pkg::t_q_stat i_qstat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output tgm_pkg::t_evt    o_evt
);
    import tgm_pkg::*;

    logic r_valid;
    t_evt r_evt;

    assign o_pop   = !i_qstat.empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_evt   = r_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_evt <= i_evt;
        end
    end

endmodule

### rtl/core/tgm_checker.sv
// port-level checks of the touch gesture to mouse block
`include "touch_gesture_to_mouse_macros.svh"

module tgm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [119:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [55:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast,
    input logic         i_cfg_we,
    input logic [2:0]   i_cfg_idx,
    input logic [15:0]  i_cfg_data
);
    import tgm_pkg::*;

    `TGM_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output word changed")

    `TGM_ASSERT_NOW(a_move_clean, m_axis_tvalid && m_axis_tuser == EV_MOVE, m_axis_tdata[55:26] == '0 && m_axis_tdata[25:0] != '0, "bad move word")

    `TGM_ASSERT_NOW(a_btn_clean, m_axis_tvalid && (m_axis_tuser == EV_PRESS || m_axis_tuser == EV_RELEASE), m_axis_tdata == '0, "button word carries motion")

    `TGM_ASSERT_NOW(a_scroll_clean, m_axis_tvalid && m_axis_tuser == EV_SCROLL, m_axis_tdata[25:0] == '0 && m_axis_tdata[53:26] != '0 && m_axis_tlast, "bad scroll word")

    `TGM_ASSERT_RST(a_reset_idle, !i_rst_n, !m_axis_tvalid && s_axis_tready, "block busy after reset")

endmodule

bind touch_gesture_to_mouse tgm_checker u_tgm_checker (.*);

### verif/tb.sv
// scoreboard and stimulus for the touch gesture to mouse block
module tb;
    import tgm_pkg::*;

    typedef struct {
        logic [1:0]         kind;
        logic signed [12:0] mx;
        logic signed [12:0] my;
        logic signed [13:0] sv;
        logic signed [13:0] sh;
        logic               lst;
    } t_exp_evt;

    class event_board;
        t_exp_evt pending[$];
        int   errors;
        int   shown;

        // gesture state and registers
        logic [3:0]  inv;
        logic [7:0]  tap_px, notch, rad;
        logic [15:0] tap_ms, dtap_ms, hold_ms, lgap_ms;
        bit          down, dragging, armed, second, primed, scrolling;
        logic [11:0] sent_x, sent_y, px, py, prx, pry, midx, midy;
        logic [31:0] t_press, t_second, t_lift, deadline, t_move;
        int          acc_v, acc_h;

        function void clear();
            inv = 0; tap_px = 10; tap_ms = 180; dtap_ms = 250; hold_ms = 200;
            notch = 24; lgap_ms = 400; rad = 14;
            down = 0; dragging = 0; armed = 0; second = 0; primed = 0; scrolling = 0;
            sent_x = 0; sent_y = 0; px = 0; py = 0; prx = 0; pry = 0; midx = 0; midy = 0;
            t_press = 0; t_second = 0; t_lift = 0; deadline = 0; t_move = 0;
            acc_v = 0; acc_h = 0;
            errors = 0; shown = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] v);
            case (idx)
                CFG_INVERT:    inv = v[3:0];
                CFG_TAP_MOVE:  tap_px = v[7:0];
                CFG_TAP_MAX:   tap_ms = v;
                CFG_DTAP_GAP:  dtap_ms = v;
                CFG_DRAG_HOLD: hold_ms = v;
                CFG_NOTCH:     notch = v[7:0];
                CFG_LHOLD_GAP: lgap_ms = v;
                CFG_LHOLD_RAD: rad = v[7:0];
                default: ;
            endcase
        endfunction

        function void push(logic [1:0] k, int mx, int my, int sv, int sh);
            t_exp_evt e;
            e.kind = k; e.mx = mx; e.my = my; e.sv = sv; e.sh = sh; e.lst = 0;
            pending.push_back(e);
        endfunction

        function void push_move(int dx, int dy);
            push(EV_MOVE, inv[0] ? -dx : dx, inv[1] ? -dy : dy, 0, 0);
        endfunction

        function int adiff(int a, int b);
            return a >= b ? a - b : b - a;
        endfunction

        function void note_sample(t_sample s);
            int n0, per, nv, nh, dx, dy, ax, ay;
            logic [31:0] now, us;
            n0 = pending.size();
            now = s.time_ms; us = s.time_us;
            if (s.touch_count >= 2) begin
                ax = (int'(s.first_x) + int'(s.second_x)) >> 1;
                ay = (int'(s.first_y) + int'(s.second_y)) >> 1;
                if (!scrolling) begin
                    scrolling = 1; acc_v = 0; acc_h = 0;
                    midx = ax; midy = ay;
                end else begin
                    per = notch == 0 ? 1 : notch;
                    acc_v += ay - int'(midy);
                    acc_h += ax - int'(midx);
                    midx = ax; midy = ay;
                    nv = acc_v / per; nh = acc_h / per;
                    if (nv != 0 || nh != 0) begin
                        acc_v -= nv * per; acc_h -= nh * per;
                        if (inv[2]) nv = -nv;
                        if (inv[3]) nh = -nh;
                        push(EV_SCROLL, 0, 0, nv, nh);
                    end
                end
            end else begin
                if (scrolling) begin
                    scrolling = 0; acc_v = 0; acc_h = 0;
                end
                if (s.touch_count == 1 && !down) begin
                    down = 1;
                    px = s.first_x; sent_x = s.first_x;
                    py = s.first_y; sent_y = s.first_y;
                    t_press = now; armed = 1;
                    if (now - t_lift <= {16'd0, dtap_ms}) begin
                        second = 1; t_second = now;
                    end else second = 0;
                    if (primed && now <= deadline && adiff(s.first_x, prx) <= rad &&
                        adiff(s.first_y, pry) <= rad) begin
                        second = 1; t_second = now;
                    end
                    primed = 0;
                end else if (s.touch_count == 1) begin
                    dx = int'(s.first_x) - int'(sent_x);
                    dy = int'(s.first_y) - int'(sent_y);
                    if (armed && (adiff(s.first_x, px) > tap_px ||
                                  adiff(s.first_y, py) > tap_px))
                        armed = 0;
                    if (second && !dragging && now - t_second >= {16'd0, hold_ms}) begin
                        dragging = 1; armed = 0;
                        push(EV_PRESS, 0, 0, 0, 0);
                    end
                    if (us - t_move > MOVE_GAP_US && (dx != 0 || dy != 0)) begin
                        push_move(dx, dy);
                        t_move = us; sent_x = s.first_x; sent_y = s.first_y;
                    end
                end else if (down) begin
                    down = 0;
                    if (dragging) begin
                        push(EV_RELEASE, 0, 0, 0, 0);
                        dragging = 0; armed = 0; second = 0; t_lift = now;
                    end else begin
                        dx = int'(s.first_x) - int'(sent_x);
                        dy = int'(s.first_y) - int'(sent_y);
                        if (dx != 0 || dy != 0) begin
                            push_move(dx, dy);
                            sent_x = s.first_x; sent_y = s.first_y;
                        end
                        if (armed && now - t_press <= {16'd0, tap_ms}) begin
                            push(EV_PRESS, 0, 0, 0, 0);
                            push(EV_RELEASE, 0, 0, 0, 0);
                        end
                        primed = 1; deadline = now + {16'd0, lgap_ms};
                        prx = sent_x; pry = sent_y;
                        armed = 0; second = 0; t_lift = now;
                    end
                end
            end
            if (pending.size() > n0) pending[pending.size()-1].lst = 1;
        endfunction

        function void check_event(logic [1:0] k, logic [55:0] d, logic l);
            t_exp_evt e;
            if (pending.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected event word kind=%0d data=%h", k, d);
                end
                return;
            end
            e = pending.pop_front();
            if (k !== e.kind || d[12:0] !== e.mx || d[25:13] !== e.my ||
                d[39:26] !== e.sv || d[53:40] !== e.sh || d[55:54] !== 2'b0 ||
                l !== e.lst) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("mismatch: exp kind=%0d mx=%0d my=%0d sv=%0d sh=%0d last=%0d",
                             e.kind, e.mx, e.my, e.sv, e.sh, e.lst);
                    $display("          got kind=%0d mx=%0d my=%0d sv=%0d sh=%0d last=%0d",
                             k, $signed(d[12:0]), $signed(d[25:13]),
                             $signed(d[39:26]), $signed(d[53:40]), l);
                end
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [55:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         i_cfg_we = 0;
    logic [2:0]   i_cfg_idx = '0;
    logic [15:0]  i_cfg_data = '0;

    event_board board;
    bit         sink_on = 0;
    int         quiet_cycles = 0;
    int         sent = 0;

    // sample time base, advanced by each generated sample
    logic [31:0] clock_ms, clock_us;
    int          cur_x, cur_y;

    touch_gesture_to_mouse uut (.*);

    always #4 i_clk = ~i_clk;

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            board.check_event(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 4000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver with random stalls; burst mode runs without stalls
    bit no_stall = 0;
    initial begin
        int g;
        forever begin
            @(posedge i_clk);
            if (!sink_on) m_axis_tready <= 0;
            else if (no_stall) m_axis_tready <= 1;
            else begin
                g = gap_len();
                if (g == 0) m_axis_tready <= 1;
                else begin
                    m_axis_tready <= 0;
                    repeat (g) @(posedge i_clk);
                    m_axis_tready <= 1;
                end
            end
        end
    end

    task send(t_sample s);
        logic [119:0] w;
        int g;
        // the front end is busy after each word until it returns to S_IDLE
        g = (no_stall ? 0 : gap_len()) + 1;
        repeat (g) @(posedge i_clk);
        w = '0;
        w[1:0] = s.touch_count; w[13:2] = s.first_x; w[25:14] = s.first_y;
        w[37:26] = s.second_x; w[49:38] = s.second_y;
        w[81:50] = s.time_ms; w[113:82] = s.time_us;
        s_axis_tvalid <= 1;
        s_axis_tdata <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_sample(s);
        sent++;
        s_axis_tvalid <= 0;
    endtask

    task sample(logic [1:0] cnt, int x1, int y1, int x2, int y2, int dms);
        t_sample s;
        clock_ms += dms;
        clock_us += dms * 1000 + $urandom_range(0, 999);
        s.touch_count = cnt;
        s.first_x = x1; s.first_y = y1; s.second_x = x2; s.second_y = y2;
        s.time_ms = clock_ms; s.time_us = clock_us;
        send(s);
    endtask

    task drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task set_reg(t_cfg_idx idx, logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        board.write_reg(idx, v);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    function int clampc(int v);
        return v < 0 ? 0 : (v > 4095 ? 4095 : v);
    endfunction

    // one gesture with random content, sometimes broken
    task gesture();
        int kind, steps, d;
        kind = $urandom_range(0, 5);
        cur_x = $urandom_range(0, 4095); cur_y = $urandom_range(0, 4095);
        case (kind)
            0: begin  // tap or double tap
                sample(1, cur_x, cur_y, 0, 0, $urandom_range(1, 300));
                sample(0, cur_x + $urandom_range(0, 1), cur_y, 0, 0, $urandom_range(1, 250));
            end
            1, 2: begin  // press, move, lift, possibly a drag
                steps = $urandom_range(1, 5);
                sample(1, cur_x, cur_y, 0, 0, $urandom_range(1, 300));
                repeat (steps) begin
                    cur_x = clampc(cur_x + $urandom_range(0, 60) - 30);
                    cur_y = clampc(cur_y + $urandom_range(0, 60) - 30);
                    sample(1, cur_x, cur_y, 0, 0, $urandom_range(1, 120));
                end
                sample(0, clampc(cur_x + $urandom_range(0, 4) - 2), cur_y, 0, 0,
                       $urandom_range(1, 60));
            end
            3: begin  // two-finger scroll
                steps = $urandom_range(2, 6);
                d = $urandom_range(20, 200);
                repeat (steps) begin
                    cur_x = clampc(cur_x + $urandom_range(0, 2 * d) - d);
                    cur_y = clampc(cur_y + $urandom_range(0, 2 * d) - d);
                    sample($urandom_range(2, 3), cur_x, cur_y,
                           $urandom_range(0, 4095), $urandom_range(0, 4095), 5);
                end
            end
            default: begin  // noise
                sample($urandom_range(0, 3), $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 1) ? $urandom_range(0, 500) : $urandom);
            end
        endcase
    endtask

    initial begin
        board = new();
        board.clear();
        clock_ms = 0; clock_us = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        sink_on = 1;

        // directed: tap, double tap and drag, lift-hold, scroll, extremes
        sample(1, 100, 100, 0, 0, 1000);
        sample(0, 100, 100, 0, 0, 50);
        sample(1, 102, 101, 0, 0, 100);
        sample(1, 110, 120, 0, 0, 250);
        sample(1, 4095, 0, 0, 0, 10);
        sample(0, 0, 4095, 0, 0, 10);
        sample(1, 5, 4090, 0, 0, 300);
        sample(0, 5, 4090, 0, 0, 500);
        sample(0, 0, 0, 0, 0, 5);
        sample(2, 0, 0, 4095, 4095, 5);
        sample(3, 4095, 4095, 4095, 4095, 5);
        sample(2, 0, 0, 0, 0, 5);
        sample(2, 1000, 200, 1000, 200, 5);
        sample(0, 0, 0, 0, 0, 5);
        clock_ms = 32'hFFFF_FFF0; clock_us = 32'hFFFF_F000;
        sample(1, 2048, 2048, 0, 0, 0);
        sample(0, 2048, 2048, 0, 0, 40);
        sample(1, 2048, 2048, 0, 0, 10);
        sample(1, 2048, 2048, 0, 0, 300);
        sample(0, 2049, 2047, 0, 0, 5);
        drain();

        set_reg(CFG_INVERT, 15); set_reg(CFG_TAP_MOVE, 255); set_reg(CFG_TAP_MAX, 65535);
        set_reg(CFG_DTAP_GAP, 0); set_reg(CFG_DRAG_HOLD, 0); set_reg(CFG_NOTCH, 0);
        set_reg(CFG_LHOLD_GAP, 65535); set_reg(CFG_LHOLD_RAD, 255);

        for (int phase = 0; phase < 4; phase++) begin
            no_stall = (phase == 2);
            while (sent < 19 + 58 * (phase + 1)) begin
                gesture();
            end
            drain();
            case (phase)
                0: begin
                    set_reg(CFG_INVERT, 0); set_reg(CFG_TAP_MOVE, 0); set_reg(CFG_TAP_MAX, 0);
                    set_reg(CFG_DTAP_GAP, 65535); set_reg(CFG_DRAG_HOLD, 65535);
                    set_reg(CFG_NOTCH, 255); set_reg(CFG_LHOLD_GAP, 0); set_reg(CFG_LHOLD_RAD, 0);
                end
                1: begin
                    set_reg(CFG_INVERT, $urandom_range(0, 15));
                    set_reg(CFG_TAP_MOVE, $urandom_range(5, 40));
                    set_reg(CFG_TAP_MAX, $urandom_range(100, 400));
                    set_reg(CFG_DTAP_GAP, $urandom_range(100, 400));
                    set_reg(CFG_DRAG_HOLD, $urandom_range(50, 300));
                    set_reg(CFG_NOTCH, $urandom_range(1, 60));
                    set_reg(CFG_LHOLD_GAP, $urandom_range(100, 800));
                    set_reg(CFG_LHOLD_RAD, $urandom_range(5, 60));
                end
                2: set_reg(CFG_NOTCH, 1);
                default: ;
            endcase
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
